// ----- src/fum_pkg.sv -----
// ----------------------------------------------------------------------------
// fum_pkg
// Shared widths, codes, constants and pipeline record types of the fisheye
// undistortion map generator.
// ----------------------------------------------------------------------------
package fum_pkg;

    localparam int TABLE_ENTRIES = 1001;
    localparam int IMAGE_DIM_MAX = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int RAD_W         = 24;
    localparam int COORD_W       = $clog2(IMAGE_DIM_MAX);
    localparam int CFG_W         = 16;
    localparam int PIX_W         = 24;
    localparam int OUT_W         = 17;
    localparam int DX_W          = COORD_W + 6;
    localparam int MAG_W         = COORD_W + 5;
    localparam int SQ_W          = 2 * MAG_W;
    localparam int SQ_IN_W       = SQ_W + 16;
    localparam int SQ_STAGES     = SQ_IN_W / 2;
    localparam int ROOT_W        = SQ_STAGES;
    localparam int CORDIC_STEPS  = 18;
    localparam int CX_W          = 46;
    localparam int Z_W           = 20;
    localparam int ANG_W         = 18;
    localparam int FRAC_W        = 8;
    localparam int ANGLE_LIMIT   = 1000 * 256;
    localparam int RQ_W          = RAD_W + FRAC_W;
    localparam int PROD_W        = MAG_W + RQ_W;
    localparam int DEN_W         = PIX_W + ROOT_W;
    localparam int NUM_W         = PROD_W + 6;
    localparam int DIV_QBITS     = 18;
    localparam int DIV_LAT       = DIV_QBITS + 1;
    localparam int SUM_W         = 20;
    localparam int OUT_MIN       = -65536;
    localparam int OUT_MAX       = 65535;
    localparam logic signed [OUT_W-1:0] UNMAPPED_VAL = -17'sd16;
    localparam logic [CFG_W-1:0] FOCAL_RESET = 16'd16384;
    localparam logic [PIX_W-1:0] PIX_RESET   = 24'd1;

    localparam logic [16:0] STEP_ANGLE [CORDIC_STEPS] = '{
        17'd115200, 17'd68007, 17'd35933, 17'd18240, 17'd9155, 17'd4582,
        17'd2292, 17'd1146, 17'd573, 17'd286, 17'd143, 17'd72,
        17'd36, 17'd18, 17'd9, 17'd4, 17'd2, 17'd1
    };

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_MAP   = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        REG_PH_CX  = 3'd0,
        REG_PH_CY  = 3'd1,
        REG_FOCAL  = 3'd2,
        REG_FE_CX  = 3'd3,
        REG_FE_CY  = 3'd4,
        REG_PIXSZ  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_W-1:0]         idx;
        logic [RAD_W-1:0]         trad;
        logic signed [DX_W-1:0]   dx;
        logic signed [DX_W-1:0]   dy;
        logic                     center;
        logic [ROOT_W-1:0]        radius;
    } early_t;

    typedef struct packed {
        logic                     cmd;
        logic                     neg_x;
        logic                     neg_y;
        logic [MAG_W-1:0]         mag_x;
        logic [MAG_W-1:0]         mag_y;
        logic                     center;
        logic                     unm;
        logic [ROOT_W-1:0]        radius;
    } late_t;

endpackage

// ----- src/fum_req_if.sv -----
// ----------------------------------------------------------------------------
// fum_req_if
// Request channel: table load or pixel map command.
// ----------------------------------------------------------------------------
interface fum_req_if import fum_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [IDX_W-1:0]   table_index;
    logic [RAD_W-1:0]   table_radius;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;

    modport source (output valid, command, table_index, table_radius, pixel_col,
                    pixel_row, input ready);
    modport sink (input valid, command, table_index, table_radius, pixel_col,
                  pixel_row, output ready);
endinterface

// ----- src/fum_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fum_rsp_if
// Result channel: fisheye source coordinate of one mapped pixel.
// ----------------------------------------------------------------------------
interface fum_rsp_if import fum_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] source_x;
    logic signed [OUT_W-1:0] source_y;
    logic                    unmapped;

    modport source (output valid, source_x, source_y, unmapped, input ready);
    modport sink (input valid, source_x, source_y, unmapped, output ready);
endinterface

// ----- src/fum_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// fum_sqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module fum_sqrt_pipe import fum_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [SQ_IN_W-1:0]  radicand,
    output logic [ROOT_W-1:0]   root
);

    logic [SQ_IN_W-1:0] rem_reg [SQ_STAGES];
    logic [SQ_IN_W-1:0] res_reg [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k);
        logic [SQ_IN_W-1:0] v_in;
        logic [SQ_IN_W-1:0] r_in;
        logic [SQ_IN_W-1:0] trial;
        logic [SQ_IN_W-1:0] rem_next;
        logic [SQ_IN_W-1:0] res_next;

        if (k == 0) begin : g_first
            assign v_in = radicand;
            assign r_in = '0;
        end else begin : g_next
            assign v_in = rem_reg[k-1];
            assign r_in = res_reg[k-1];
        end

        always_comb
        begin
            trial = r_in + BIT;
            if (v_in >= trial)
            begin
                rem_next = v_in - trial;
                res_next = (r_in >> 1) + BIT;
            end
            else
            begin
                rem_next = v_in;
                res_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign root = res_reg[SQ_STAGES-1][ROOT_W-1:0];

endmodule

// ----- src/fum_cordic_pipe.sv -----
// ----------------------------------------------------------------------------
// fum_cordic_pipe
// Pipelined CORDIC vectoring that gives the ray angle atan2(radius, focal).
// ----------------------------------------------------------------------------
module fum_cordic_pipe import fum_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [CFG_W-1:0]       focal,
    input  logic [ROOT_W-1:0]      radius,
    output logic signed [Z_W-1:0]  angle
);

    logic signed [CX_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [CX_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg [CORDIC_STEPS];

    // Shifts round toward zero, not toward minus infinity.
    function automatic logic signed [CX_W-1:0] shr_trunc(input logic signed [CX_W-1:0] v,
                                                         input int s);
        logic signed [CX_W-1:0] r;
        if (v < 0)
            r = -((-v) >>> s);
        else
            r = v >>> s;
        return r;
    endfunction

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [CX_W-1:0] x_in;
        logic signed [CX_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        logic signed [Z_W-1:0]  step;

        if (k == 0) begin : g_first
            assign x_in = $signed(CX_W'({focal, 24'd0}));
            assign y_in = $signed(CX_W'({radius, 16'd0}));
            assign z_in = '0;
        end else begin : g_next
            assign x_in = x_reg[k-1];
            assign y_in = y_reg[k-1];
            assign z_in = z_reg[k-1];
        end

        assign xs   = shr_trunc(x_in, k);
        assign ys   = shr_trunc(y_in, k);
        assign step = $signed(Z_W'(STEP_ANGLE[k]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_in >= 0)
                begin
                    x_reg[k] <= x_in + ys;
                    y_reg[k] <= y_in - xs;
                    z_reg[k] <= z_in + step;
                end
                else
                begin
                    x_reg[k] <= x_in - ys;
                    y_reg[k] <= y_in + xs;
                    z_reg[k] <= z_in - step;
                end
            end
        end
    end

    assign angle = z_reg[CORDIC_STEPS-1];

endmodule

// ----- src/fum_table_mem.sv -----
// ----------------------------------------------------------------------------
// fum_table_mem
// Angle-to-radius table memory with two read ports and linear interpolation.
// ----------------------------------------------------------------------------
module fum_table_mem import fum_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic               we,
    input  logic [IDX_W-1:0]   waddr,
    input  logic [RAD_W-1:0]   wdata,
    input  logic [IDX_W-1:0]   raddr_lo,
    input  logic [IDX_W-1:0]   raddr_hi,
    input  logic [FRAC_W-1:0]  frac,
    output logic [RQ_W-1:0]    rq
);

    logic [RAD_W-1:0]  mem [TABLE_ENTRIES];
    logic [RAD_W-1:0]  rf_reg;
    logic [RAD_W-1:0]  rc_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [RQ_W-1:0]   rq_reg;
    logic [RAD_W-1:0]  rc_eff;
    logic [FRAC_W:0]   w_lo;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[waddr] <= wdata;
            rf_reg   <= mem[raddr_lo];
            rc_reg   <= mem[raddr_hi];
            frac_reg <= frac;
        end
    end

    // With a zero fraction the upper entry is not needed and may lie past the end.
    assign rc_eff = (frac_reg == '0) ? '0 : rc_reg;
    assign w_lo   = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(frac_reg);

    always_ff @(posedge clk)
    begin
        if (en)
            rq_reg <= RQ_W'(rf_reg * w_lo) + RQ_W'(rc_eff * frac_reg);
    end

    assign rq = rq_reg;

endmodule

// ----- src/fum_div_pipe.sv -----
// ----------------------------------------------------------------------------
// fum_div_pipe
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module fum_div_pipe import fum_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output logic [DIV_QBITS-1:0]  quot
);

    localparam int TOP_W = NUM_W - DIV_QBITS;

    logic [DEN_W-1:0]     rem_reg [DIV_QBITS+1];
    logic [DEN_W-1:0]     den_reg [DIV_QBITS+1];
    logic [DIV_QBITS-1:0] low_reg [DIV_QBITS+1];
    logic [DIV_QBITS-1:0] q_reg   [DIV_QBITS+1];
    logic                 ovf_reg [DIV_QBITS+1];
    logic [TOP_W-1:0]     num_top;

    assign num_top = num[NUM_W-1:DIV_QBITS];

    // A quotient that needs more bits than kept is saturated.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= DEN_W'(num_top) >= den;
            rem_reg[0] <= DEN_W'(num_top);
            den_reg[0] <= den;
            low_reg[0] <= num[DIV_QBITS-1:0];
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= DIV_QBITS; k++) begin : g_step
        logic [DEN_W:0] shifted;
        logic [DEN_W:0] diff;
        logic           take;

        assign shifted = {rem_reg[k-1], low_reg[k-1][DIV_QBITS-1]};
        assign diff    = shifted - {1'b0, den_reg[k-1]};
        assign take    = shifted >= {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                den_reg[k] <= den_reg[k-1];
                low_reg[k] <= low_reg[k-1] << 1;
                q_reg[k]   <= {q_reg[k-1][DIV_QBITS-2:0], take};
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quot = ovf_reg[DIV_QBITS] ? '1 : q_reg[DIV_QBITS];

endmodule

// ----- src/fisheye_undistort_map_generator.sv -----
// Throughput: one request per clock; the sqrt, CORDIC and divider pipelines
// each take one step per stage, and the whole pipeline stalls only while a
// result waits at the output. Table loads return no result.
// Reset sets the configuration registers to their defaults and clears the
// pipeline valids and the table-loaded flag; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
// fisheye_undistort_map_generator
// Maps pinhole output pixels to fisheye source coordinates through a loaded
// angle-to-radius table, with an APB register port.
// ----------------------------------------------------------------------------
module fisheye_undistort_map_generator import fum_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fum_req_if.sink     req,
    fum_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int EARLY_LEN = 2 + SQ_STAGES + CORDIC_STEPS;
    localparam int CORDIC_IN = 1 + SQ_STAGES;
    localparam int TABLE_IN  = EARLY_LEN - 1;
    localparam int MUL_IDX   = 1;
    localparam int DIV_IN    = 2;
    localparam int LATE_LEN  = DIV_IN + DIV_LAT + 1;
    localparam int FIN_IDX   = LATE_LEN - 1;

    // Configuration registers
    logic [CFG_W-1:0] ph_cx_reg, ph_cy_reg, focal_reg, fe_cx_reg, fe_cy_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_cx_reg <= '0;
            ph_cy_reg <= '0;
            focal_reg <= FOCAL_RESET;
            fe_cx_reg <= '0;
            fe_cy_reg <= '0;
            pix_reg   <= PIX_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_PH_CX: ph_cx_reg <= pwdata[CFG_W-1:0];
                REG_PH_CY: ph_cy_reg <= pwdata[CFG_W-1:0];
                REG_FOCAL: focal_reg <= pwdata[CFG_W-1:0];
                REG_FE_CX: fe_cx_reg <= pwdata[CFG_W-1:0];
                REG_FE_CY: fe_cy_reg <= pwdata[CFG_W-1:0];
                REG_PIXSZ: pix_reg   <= pwdata[PIX_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_PH_CX: prdata = 32'(ph_cx_reg);
            REG_PH_CY: prdata = 32'(ph_cy_reg);
            REG_FOCAL: prdata = 32'(focal_reg);
            REG_FE_CX: prdata = 32'(fe_cx_reg);
            REG_FE_CY: prdata = 32'(fe_cy_reg);
            REG_PIXSZ: prdata = 32'(pix_reg);
            default:   prdata = '0;
        endcase
    end

    // Pipeline control
    logic                    adv;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] out_x_reg, out_y_reg;
    logic                    out_unm_reg;

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    logic   ev_reg [EARLY_LEN];
    early_t early_reg [EARLY_LEN];
    logic   lv_reg [LATE_LEN];
    late_t  late_reg [LATE_LEN];
    logic   loaded_reg;

    // Input stage: pixel offset from the pinhole center
    early_t early_in;

    always_comb
    begin
        early_in        = '0;
        early_in.cmd    = req.command;
        early_in.idx    = req.table_index;
        early_in.trad   = req.table_radius;
        early_in.dx     = $signed({2'b00, req.pixel_col, 4'b0000}) -
                          $signed({2'b00, ph_cx_reg});
        early_in.dy     = $signed({2'b00, req.pixel_row, 4'b0000}) -
                          $signed({2'b00, ph_cy_reg});
        early_in.center = (early_in.dx == '0) && (early_in.dy == '0);
    end

    // Squared radius
    logic [MAG_W-1:0] mx0, my0;
    logic [SQ_W-1:0]  sq_now, sq_reg;

    assign mx0        = early_reg[0].dx[DX_W-1] ? MAG_W'(-early_reg[0].dx)
                                                 : MAG_W'(early_reg[0].dx);
    assign my0        = early_reg[0].dy[DX_W-1] ? MAG_W'(-early_reg[0].dy)
                                                 : MAG_W'(early_reg[0].dy);
    assign sq_now     = SQ_W'(mx0 * mx0) + SQ_W'(my0 * my0);

    logic [ROOT_W-1:0]     root;
    logic signed [Z_W-1:0] angle;

    fum_sqrt_pipe u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand ({sq_reg, 16'd0}),
        .root     (root)
    );

    fum_cordic_pipe u_cordic (
        .clk    (clk),
        .en     (adv),
        .focal  (focal_reg),
        .radius (root),
        .angle  (angle)
    );

    early_t early_next [EARLY_LEN];

    // The root joins the record as it enters the CORDIC stages.
    always_comb
    begin
        early_next[0] = early_in;
        for (int i = 1; i < EARLY_LEN; i++)
            early_next[i] = early_reg[i-1];
        early_next[CORDIC_IN+1].radius = root;
    end

    // Angle to table slot
    logic [ANG_W-1:0]  ang;
    logic [IDX_W-1:0]  fi;
    logic [FRAC_W-1:0] frac;
    logic              bad;
    logic              tbl_we;
    early_t            e_last;
    late_t             late_in;

    assign e_last = early_reg[TABLE_IN];
    assign ang    = angle[Z_W-1] ? '0 : angle[ANG_W-1:0];
    assign fi     = ang[ANG_W-1:FRAC_W];
    assign frac   = ang[FRAC_W-1:0];
    assign bad    = (32'(ang) > ANGLE_LIMIT) || (32'(fi) >= TABLE_ENTRIES) ||
                    ((frac != '0) && (32'(fi) + 1 >= TABLE_ENTRIES));
    assign tbl_we = adv && ev_reg[TABLE_IN] && (e_last.cmd == CMD_WRITE) &&
                    (32'(e_last.idx) < TABLE_ENTRIES);

    always_comb
    begin
        late_in        = '0;
        late_in.cmd    = e_last.cmd;
        late_in.neg_x  = e_last.dx[DX_W-1];
        late_in.neg_y  = e_last.dy[DX_W-1];
        late_in.mag_x  = e_last.dx[DX_W-1] ? MAG_W'(-e_last.dx) : MAG_W'(e_last.dx);
        late_in.mag_y  = e_last.dy[DX_W-1] ? MAG_W'(-e_last.dy) : MAG_W'(e_last.dy);
        late_in.center = e_last.center;
        late_in.unm    = !loaded_reg || (!e_last.center && bad);
        late_in.radius = e_last.radius;
    end

    logic [RQ_W-1:0] rq;

    fum_table_mem u_table (
        .clk      (clk),
        .en       (adv),
        .we       (tbl_we),
        .waddr    (e_last.idx),
        .wdata    (e_last.trad),
        .raddr_lo (fi),
        .raddr_hi (fi + IDX_W'(1)),
        .frac     (frac),
        .rq       (rq)
    );

    // Scaling products and division
    logic [PIX_W-1:0]     pix_eff;
    logic [PROD_W-1:0]    px_reg, py_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [NUM_W-1:0]     num_x, num_y;
    logic [DIV_QBITS-1:0] qx, qy;

    assign pix_eff = (pix_reg == '0) ? PIX_W'(1) : pix_reg;
    assign num_x   = NUM_W'({px_reg, 4'b0000}) + NUM_W'(den_reg >> 1);
    assign num_y   = NUM_W'({py_reg, 4'b0000}) + NUM_W'(den_reg >> 1);

    fum_div_pipe u_div_x (
        .clk  (clk),
        .en   (adv),
        .num  (num_x),
        .den  (den_reg),
        .quot (qx)
    );

    fum_div_pipe u_div_y (
        .clk  (clk),
        .en   (adv),
        .num  (num_y),
        .den  (den_reg),
        .quot (qy)
    );

    // Final offset, center add and saturation
    late_t                   l_fin;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic signed [OUT_W-1:0] res_x, res_y;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SUM_W'(OUT_MAX))
            r = OUT_W'(OUT_MAX);
        else if (v < SUM_W'(OUT_MIN))
            r = OUT_W'(OUT_MIN);
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

    assign l_fin = late_reg[FIN_IDX];
    assign sum_x = l_fin.neg_x ? $signed({4'b0000, fe_cx_reg}) - $signed({2'b00, qx})
                               : $signed({4'b0000, fe_cx_reg}) + $signed({2'b00, qx});
    assign sum_y = l_fin.neg_y ? $signed({4'b0000, fe_cy_reg}) - $signed({2'b00, qy})
                               : $signed({4'b0000, fe_cy_reg}) + $signed({2'b00, qy});

    always_comb
    begin
        priority if (l_fin.unm)
        begin
            res_x = UNMAPPED_VAL;
            res_y = UNMAPPED_VAL;
        end
        else if (l_fin.center)
        begin
            res_x = $signed({1'b0, fe_cx_reg});
            res_y = $signed({1'b0, fe_cy_reg});
        end
        else
        begin
            res_x = sat_out(sum_x);
            res_y = sat_out(sum_y);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < EARLY_LEN; i++)
                ev_reg[i] <= 1'b0;
            for (int i = 0; i < LATE_LEN; i++)
                lv_reg[i] <= 1'b0;
            loaded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ev_reg[0] <= req.valid;
            for (int i = 1; i < EARLY_LEN; i++)
                ev_reg[i] <= ev_reg[i-1];
            lv_reg[0] <= ev_reg[TABLE_IN];
            for (int i = 1; i < LATE_LEN; i++)
                lv_reg[i] <= lv_reg[i-1];
            if (tbl_we)
                loaded_reg <= 1'b1;
            out_valid_reg <= lv_reg[FIN_IDX] && (l_fin.cmd == CMD_MAP);
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < EARLY_LEN; i++)
                early_reg[i] <= early_next[i];
            sq_reg <= sq_now;

            late_reg[0] <= late_in;
            for (int i = 1; i < LATE_LEN; i++)
                late_reg[i] <= late_reg[i-1];
            px_reg  <= PROD_W'(late_reg[MUL_IDX].mag_x * rq);
            py_reg  <= PROD_W'(late_reg[MUL_IDX].mag_y * rq);
            den_reg <= DEN_W'(pix_eff * late_reg[MUL_IDX].radius);

            out_x_reg   <= res_x;
            out_y_reg   <= res_y;
            out_unm_reg <= l_fin.unm;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.source_x = out_x_reg;
    assign rsp.source_y = out_y_reg;
    assign rsp.unmapped = out_unm_reg;

`ifndef SYNTHESIS
    a_unmapped_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.unmapped) |->
        (rsp.source_x == UNMAPPED_VAL && rsp.source_y == UNMAPPED_VAL))
        else $error("unmapped result without the unmapped coordinate");

    a_loaded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(loaded_reg))
        else $error("table loaded flag cleared outside reset");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(ev_reg[0]) && $stable(lv_reg[FIN_IDX])))
        else $error("pipeline moved during a stall");
`endif

endmodule
